// File: rtl/spimc_pkg.sv
package spimc_pkg;

    localparam int unsigned DATA_W         = 16;
    localparam int unsigned LEN_W          = 4;
    localparam int unsigned BITS_W         = 5;
    localparam int unsigned DELAY_W        = 8;
    localparam int unsigned MAX_FRAME_BITS = 16;
    localparam int unsigned QUEUE_DEPTH    = 2;

    // Control register bit positions.
    localparam int unsigned CTL_IRQEN  = 6;
    localparam int unsigned CTL_FLAG   = 7;
    localparam int unsigned CTL_XCH    = 8;
    localparam int unsigned CTL_ENABLE = 9;

    // Bus command codes.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_SHIFT = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic SEL_DATA = 1'b0;
    localparam logic SEL_CTRL = 1'b1;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd16;

    typedef enum logic [2:0] {
        OP_READ_DATA,
        OP_READ_CTRL,
        OP_WRITE_DATA,
        OP_WRITE_CTRL,
        OP_SHIFT,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] value;      // control writes arrive with the exchange bit cleared
        logic              start_req;  // control write with enable and exchange set
        logic              miso;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              mosi_bit;
        logic              mosi_valid;
        logic              frame_last;
        logic              busy;
        logic              irq;
    } result_t;

endpackage

// File: rtl/spimc_front.sv
module spimc_front (
    input  logic                [1:0]  command,
    input  logic                       reg_select,
    input  logic [spimc_pkg::DATA_W-1:0] write_value,
    input  logic                       miso_bit,
    output spimc_pkg::item_t           item
);
    import spimc_pkg::*;

    logic [DATA_W-1:0] ctrl_value;

    always_comb
    begin
        ctrl_value          = write_value;
        ctrl_value[CTL_XCH] = 1'b0;
    end

    always_comb
    begin
        item.value     = write_value;
        item.start_req = 1'b0;
        item.miso      = miso_bit;
        case (command)
            CMD_READ:
            begin
                item.op = (reg_select == SEL_CTRL) ? OP_READ_CTRL : OP_READ_DATA;
            end
            CMD_WRITE:
            begin
                if (reg_select == SEL_CTRL)
                begin
                    item.op        = OP_WRITE_CTRL;
                    item.value     = ctrl_value;
                    item.start_req = write_value[CTL_ENABLE] & write_value[CTL_XCH];
                end
                else
                begin
                    item.op = OP_WRITE_DATA;
                end
            end
            CMD_SHIFT:
            begin
                item.op = OP_SHIFT;
            end
            CMD_TICK:
            begin
                item.op = OP_TICK;
            end
            default:
            begin
                item.op = OP_TICK;
            end
        endcase
    end

endmodule

// File: rtl/spimc_queue.sv
module spimc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  spimc_pkg::item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output spimc_pkg::item_t head_item
);
    import spimc_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/spimc_back.sv
module spimc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [spimc_pkg::DELAY_W-1:0] cfg_delay,
    input  logic                          item_valid,
    input  spimc_pkg::item_t              item,
    output logic                          item_pop,
    output logic                          res_valid,
    output spimc_pkg::result_t            res,
    input  logic                          res_ready
);
    import spimc_pkg::*;

    logic [DELAY_W-1:0] delay_cfg_reg;
    logic [DATA_W-1:0]  control_reg, control_next;
    logic [DATA_W-1:0]  transmit_reg, transmit_next;
    logic [DATA_W-1:0]  frame_reg, frame_next;
    logic [DATA_W-1:0]  receive_reg, receive_next;
    logic               running_reg, running_next;
    logic [BITS_W-1:0]  bits_left_reg, bits_left_next;
    logic [DELAY_W-1:0] delay_count_reg, delay_count_next;
    logic               irq_reg, irq_next;
    logic               res_valid_reg;
    result_t            res_reg, res_next;

    logic [BITS_W-1:0]  start_len;
    logic [BITS_W-1:0]  bit_index;
    logic [DATA_W-1:0]  start_mask;

    function automatic logic [BITS_W-1:0] frame_len(input logic [LEN_W-1:0] len_field);
        logic [BITS_W-1:0] n;
        n = BITS_W'(len_field) + 1'b1;
        if (n > BITS_W'(MAX_FRAME_BITS))
        begin
            n = BITS_W'(MAX_FRAME_BITS);
        end
        return n;
    endfunction

    // The output register frees up when empty or when its result is taken.
    assign item_pop  = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign start_len  = frame_len(item.value[LEN_W-1:0]);
    assign start_mask = {DATA_W{1'b1}} >> (BITS_W'(DATA_W) - start_len);
    assign bit_index  = bits_left_reg - 1'b1;

    always_comb
    begin
        control_next     = control_reg;
        transmit_next    = transmit_reg;
        frame_next       = frame_reg;
        receive_next     = receive_reg;
        running_next     = running_reg;
        bits_left_next   = bits_left_reg;
        delay_count_next = delay_count_reg;
        irq_next         = irq_reg;
        res_next         = '0;

        case (item.op)
            OP_READ_DATA:
            begin
                res_next.read_data = receive_reg;
            end
            OP_READ_CTRL:
            begin
                res_next.read_data          = control_reg;
                res_next.read_data[CTL_XCH] = running_reg;
            end
            OP_WRITE_DATA:
            begin
                transmit_next = item.value;
            end
            OP_WRITE_CTRL:
            begin
                control_next = item.value;
                if (!item.value[CTL_FLAG])
                begin
                    irq_next = 1'b0;
                end
                if (item.start_req)
                begin
                    // A frame still pending is flagged complete (when IRQEN is set) as the new one starts.
                    if (running_reg && item.value[CTL_IRQEN])
                    begin
                        control_next[CTL_FLAG] = 1'b1;
                        irq_next               = 1'b1;
                    end
                    frame_next       = transmit_reg & start_mask;
                    bits_left_next   = start_len;
                    receive_next     = '0;
                    running_next     = 1'b1;
                    delay_count_next = delay_cfg_reg;
                end
            end
            OP_SHIFT:
            begin
                if (bits_left_reg != '0)
                begin
                    bits_left_next      = bit_index;
                    res_next.mosi_bit   = frame_reg[bit_index[LEN_W-1:0]];
                    res_next.mosi_valid = 1'b1;
                    res_next.frame_last = (bit_index == '0);
                    receive_next        = {receive_reg[DATA_W-2:0], item.miso};
                end
            end
            OP_TICK:
            begin
                if (running_reg)
                begin
                    if (delay_count_reg <= DELAY_W'(1))
                    begin
                        running_next     = 1'b0;
                        bits_left_next   = '0;
                        delay_count_next = '0;
                        if (control_reg[CTL_IRQEN])
                        begin
                            control_next[CTL_FLAG] = 1'b1;
                            irq_next               = 1'b1;
                        end
                    end
                    else
                    begin
                        delay_count_next = delay_count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase

        res_next.busy = running_next;
        res_next.irq  = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_cfg_reg   <= DELAY_RESET;
            control_reg     <= '0;
            transmit_reg    <= '0;
            frame_reg       <= '0;
            receive_reg     <= '0;
            running_reg     <= 1'b0;
            bits_left_reg   <= '0;
            delay_count_reg <= '0;
            irq_reg         <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                delay_cfg_reg <= cfg_delay;
            end
            if (item_pop)
            begin
                control_reg     <= control_next;
                transmit_reg    <= transmit_next;
                frame_reg       <= frame_next;
                receive_reg     <= receive_next;
                running_reg     <= running_next;
                bits_left_reg   <= bits_left_next;
                delay_count_reg <= delay_count_next;
                irq_reg         <= irq_next;
                res_valid_reg   <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            res_reg <= res_next;
        end
    end

    a_bits_imply_running: assert property (@(posedge clk) disable iff (!rst_n)
        (bits_left_reg != '0) |-> running_reg)
        else $error("frame bits left with no exchange running");

    a_bits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg <= BITS_W'(MAX_FRAME_BITS))
        else $error("bit counter beyond frame length");

    a_irq_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
        irq_reg |-> control_reg[CTL_FLAG])
        else $error("interrupt line high with flag clear");

    a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.frame_last) |-> res_reg.mosi_valid)
        else $error("frame end marked on an item that moved no bit");

    a_idle_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (item_pop && item.op == OP_SHIFT && !running_reg) |=> !res_reg.mosi_valid)
        else $error("bit moved while no exchange was running");

endmodule

// File: rtl/spi_master_with_control_register.sv
// SPI master with data and control registers, one item per command transfer.
// A command passes through the command queue, then the execute stage's output register,
// before its result appears. Throughput: one item per clock while results are taken;
// m_tready low holds the output register and stalls the execute stage.
// Reset (rst_n, asynchronous, active low) clears the control, data and state registers,
// empties the queue, and sets the completion delay to 16 ticks.
module spi_master_with_control_register (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] write_value, [16] miso_bit, rest zero
    input  logic [2:0]  s_tuser,   // [1:0] command, [2] reg_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] read_data, [16] mosi_bit, [17] busy_res,
                                   // [18] irq_line, rest zero
    output logic [0:0]  m_tuser,   // [0] mosi_valid
    output logic        m_tlast,   // frame_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import spimc_pkg::*;

    item_t   front_item;
    item_t   head_item;
    logic    queue_full;
    logic    queue_not_empty;
    logic    queue_pop;
    result_t res;

    assign s_tready  = !queue_full;
    assign cfg_ready = 1'b1;

    spimc_front u_front (
        .command     (s_tuser[1:0]),
        .reg_select  (s_tuser[2]),
        .write_value (s_tdata[15:0]),
        .miso_bit    (s_tdata[16]),
        .item        (front_item)
    );

    spimc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head_item (head_item)
    );

    spimc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_delay  (cfg_data),
        .item_valid (queue_not_empty),
        .item       (head_item),
        .item_pop   (queue_pop),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    assign m_tdata    = {5'b0, res.irq, res.busy, res.mosi_bit, res.read_data};
    assign m_tuser[0] = res.mosi_valid;
    assign m_tlast    = res.frame_last;

endmodule
